>>> hw/rtl/ctpc_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, constants and helpers of the capsule containment table.
package ctpc_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam logic [15:0] ZSCALE_RESET = 16'd256;

  // Multi-word arithmetic: 33-bit limbs, operands up to four limbs
  localparam int LIMB_W   = 33;
  localparam int MAX_LIMBS = 4;
  localparam int OPND_W   = LIMB_W * MAX_LIMBS;
  localparam int PROD_W   = 2 * LIMB_W;
  localparam int ACC_W    = 200;
  localparam int RAD_W    = 23;
  localparam int ZPROD_W  = 49;

  // Item kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // One stored capsule, z already scaled, radii clamped
  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic [RAD_W-1:0]   rad_b;
    logic [RAD_W-1:0]   rad_a;
  } capsule_t;

  // Test unit result
  typedef struct packed {
    logic done;
    logic hit;
  } test_res_t;

  // Operands of the test unit; the nine differences come first
  typedef enum logic [4:0] {
    OP_ABX, OP_ABY, OP_ABZ,
    OP_APX, OP_APY, OP_APZ,
    OP_BPX, OP_BPY, OP_BPZ,
    OP_RA, OP_RB, OP_RD,
    OP_L, OP_D, OP_AP2, OP_N, OP_T
  } op_t;

  // Sums of products evaluated by the test unit
  typedef enum logic [2:0] {
    G_SPA, G_SPB, G_L, G_D, G_AP2, G_N, G_T, G_F
  } grp_t;

  typedef struct packed {
    op_t  x;
    op_t  y;
    logic sub;
    logic last;
  } term_t;

  function automatic term_t mk(op_t x, op_t y, logic sub, logic last);
    term_t r;
    r.x    = x;
    r.y    = y;
    r.sub  = sub;
    r.last = last;
    return r;
  endfunction

  // Term t of group g: acc +/-= x * y
  function automatic term_t term_of(grp_t g, logic [1:0] t);
    term_t r;
    r = mk(OP_RA, OP_RA, 1'b0, 1'b1);
    case (g)
      G_SPA: begin
        case (t)
          2'd0: r = mk(OP_APX, OP_APX, 1'b0, 1'b0);
          2'd1: r = mk(OP_APY, OP_APY, 1'b0, 1'b0);
          2'd2: r = mk(OP_APZ, OP_APZ, 1'b0, 1'b0);
          default: r = mk(OP_RA, OP_RA, 1'b1, 1'b1);
        endcase
      end
      G_SPB: begin
        case (t)
          2'd0: r = mk(OP_BPX, OP_BPX, 1'b0, 1'b0);
          2'd1: r = mk(OP_BPY, OP_BPY, 1'b0, 1'b0);
          2'd2: r = mk(OP_BPZ, OP_BPZ, 1'b0, 1'b0);
          default: r = mk(OP_RB, OP_RB, 1'b1, 1'b1);
        endcase
      end
      G_L: begin
        case (t)
          2'd0: r = mk(OP_ABX, OP_ABX, 1'b0, 1'b0);
          2'd1: r = mk(OP_ABY, OP_ABY, 1'b0, 1'b0);
          default: r = mk(OP_ABZ, OP_ABZ, 1'b0, 1'b1);
        endcase
      end
      G_D: begin
        case (t)
          2'd0: r = mk(OP_APX, OP_ABX, 1'b0, 1'b0);
          2'd1: r = mk(OP_APY, OP_ABY, 1'b0, 1'b0);
          default: r = mk(OP_APZ, OP_ABZ, 1'b0, 1'b1);
        endcase
      end
      G_AP2: begin
        case (t)
          2'd0: r = mk(OP_APX, OP_APX, 1'b0, 1'b0);
          2'd1: r = mk(OP_APY, OP_APY, 1'b0, 1'b0);
          default: r = mk(OP_APZ, OP_APZ, 1'b0, 1'b1);
        endcase
      end
      G_N: begin
        case (t)
          2'd0: r = mk(OP_RA, OP_L, 1'b0, 1'b0);
          default: r = mk(OP_D, OP_RD, 1'b0, 1'b1);
        endcase
      end
      G_T: begin
        case (t)
          2'd0: r = mk(OP_AP2, OP_L, 1'b0, 1'b0);
          default: r = mk(OP_D, OP_D, 1'b1, 1'b1);
        endcase
      end
      G_F: begin
        case (t)
          2'd0: r = mk(OP_T, OP_L, 1'b0, 1'b0);
          default: r = mk(OP_N, OP_N, 1'b1, 1'b1);
        endcase
      end
      default: r = mk(OP_RA, OP_RA, 1'b0, 1'b1);
    endcase
    return r;
  endfunction

  // Index of the top limb of an operand
  function automatic logic [1:0] op_limbs(op_t op);
    logic [1:0] r;
    case (op)
      OP_L, OP_D, OP_AP2: r = 2'd1;
      OP_N:               r = 2'd2;
      OP_T:               r = 2'd3;
      default:            r = 2'd0;
    endcase
    return r;
  endfunction

  // z * scale / 256 (floor), saturated to 32 bits
  function automatic logic signed [31:0] sat_z(logic signed [ZPROD_W-1:0] p);
    logic signed [ZPROD_W-9:0] q;
    logic signed [31:0] r;
    q = p[ZPROD_W-1:8];
    if (q[ZPROD_W-9:31] != {(ZPROD_W-39){q[ZPROD_W-9]}})
      r = q[ZPROD_W-9] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else
      r = q[31:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/capsule_table_point_containment.sv
`timescale 1ns / 1ps
// Top level: capsule table in RAM, item sequencer and result register.
//
//  Channel  Signals                           Direction  Transaction
//  in       in_valid/in_ready + item fields   input      one item (insert, query, clear)
//  out      out_valid/out_ready + result      output     one result per item
//  cfg      cfg_wr_en/cfg_wr_data             input      z_scale write, no handshake
//
// A query reads each stored capsule tested from RAM and passes it to the test
// unit, whose single 33x33 multiplier works through the limb products.
// The scan stops at the first capsule that holds the point.
// Reset clears the entry count but not the table contents, which need no clearing.
// A new item is taken while the previous result waits in the output register.
module capsule_table_point_containment #(
  parameter int TABLE_DEPTH = ctpc_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           kind,
  input  logic signed [31:0]                   end_a_x,
  input  logic signed [31:0]                   end_a_y,
  input  logic signed [31:0]                   end_a_z,
  input  logic signed [31:0]                   end_b_x,
  input  logic signed [31:0]                   end_b_y,
  input  logic signed [31:0]                   end_b_z,
  input  logic signed [23:0]                   radius_a,
  input  logic signed [23:0]                   radius_b,
  input  logic signed [31:0]                   point_x,
  input  logic signed [31:0]                   point_y,
  input  logic signed [31:0]                   point_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 inside_res,
  output logic                                 status,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     stored_count,
  input  logic                                 cfg_wr_en,
  input  logic [15:0]                          cfg_wr_data
);
  import ctpc_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CAP_W = $bits(capsule_t);

  typedef enum logic [2:0] {
    S_IDLE, S_ZMUL, S_INS, S_QZ, S_RD, S_LOAD, S_TEST, S_DONE
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count, idx;
  logic [15:0] zscale;
  logic res_inside, res_status;

  // Item registers
  logic [1:0]          kind_q;
  logic signed [31:0]  ax_q, ay_q, za_q, bx_q, by_q, bz_q, px_q, py_q, pz_s;
  logic signed [23:0]  ra_q, rb_q;
  logic signed [ZPROD_W-1:0] prod_a, prod_b;

  logic full, ram_we;
  capsule_t wcap;
  logic [CAP_W-1:0] rdata;
  test_res_t test_res;

  assign in_ready = (state == S_IDLE);
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign ram_we   = (state == S_INS) && !full;

  // Capsule as stored
  always_comb begin
    wcap.a_x   = ax_q;
    wcap.a_y   = ay_q;
    wcap.a_z   = sat_z(prod_a);
    wcap.b_x   = bx_q;
    wcap.b_y   = by_q;
    wcap.b_z   = sat_z(prod_b);
    wcap.rad_a = ra_q[23] ? '0 : ra_q[RAD_W-1:0];
    wcap.rad_b = rb_q[23] ? '0 : rb_q[RAD_W-1:0];
  end

  ctpc_ram #(
    .WIDTH (CAP_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (wcap),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  ctpc_test u_test (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_LOAD),
    .cap   (capsule_t'(rdata)),
    .pt_x  (px_q),
    .pt_y  (py_q),
    .pt_z  (pz_s),
    .res   (test_res)
  );

  // Sequencer, entry count, z scale and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      idx        <= '0;
      zscale     <= ZSCALE_RESET;
      res_inside <= 1'b0;
      res_status <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_inside <= 1'b0;
            res_status <= 1'b0;
            state      <= S_ZMUL;
          end
        end
        S_ZMUL: begin
          case (kind_q)
            KIND_INSERT: state <= S_INS;
            KIND_QUERY:  state <= S_QZ;
            KIND_CLEAR: begin
              count <= '0;
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_INS: begin
          if (full)
            res_status <= 1'b1;
          else
            count <= count + 1'b1;
          state <= S_DONE;
        end
        S_QZ: begin
          idx   <= '0;
          state <= (count == '0) ? S_DONE : S_RD;
        end
        S_RD:   state <= S_LOAD;
        S_LOAD: state <= S_TEST;
        S_TEST: begin
          if (test_res.done) begin
            if (test_res.hit) begin
              res_inside <= 1'b1;
              state      <= S_DONE;
            end else if (CNT_W'(idx + 1'b1) == count) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            inside_res   <= res_inside;
            status       <= res_status;
            stored_count <= count;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Result register drains when the receiver takes it
      if (out_ready && state != S_DONE)
        out_valid <= 1'b0;
      // z scale write empties the table when the value changes to a nonzero value
      if (cfg_wr_en && cfg_wr_data != '0 && cfg_wr_data != zscale) begin
        zscale <= cfg_wr_data;
        count  <= '0;
      end
    end
  end

  // Item capture and z scaling
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      kind_q <= kind;
      ax_q   <= end_a_x;
      ay_q   <= end_a_y;
      za_q   <= (kind == KIND_QUERY) ? point_z : end_a_z;
      bx_q   <= end_b_x;
      by_q   <= end_b_y;
      bz_q   <= end_b_z;
      ra_q   <= radius_a;
      rb_q   <= radius_b;
      px_q   <= point_x;
      py_q   <= point_y;
    end
    if (state == S_ZMUL) begin
      prod_a <= ZPROD_W'(za_q) * ZPROD_W'($signed({1'b0, zscale}));
      prod_b <= ZPROD_W'(bz_q) * ZPROD_W'($signed({1'b0, zscale}));
    end
    if (state == S_QZ)
      pz_s <= sat_z(prod_a);
  end

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> stored_count == CNT_W'(TABLE_DEPTH))
    else $error("dropped insert reported with table not full");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> count < CNT_W'(TABLE_DEPTH))
    else $error("table write beyond depth");

  a_test_done_waited: assert property (@(posedge clk) disable iff (rst)
    test_res.done |-> state == S_TEST)
    else $error("test result outside of scan wait");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> idx < count)
    else $error("scan reads an entry past the count");

  a_hit_needs_entries: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_res |-> stored_count != '0)
    else $error("hit reported on an empty table");

endmodule

>>> hw/rtl/ctpc_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
module ctpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ctpc_test.sv
`timescale 1ns / 1ps
// Capsule test unit: exact containment test on one shared 33x33 multiplier.
module ctpc_test (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ctpc_pkg::capsule_t    cap,
  input  logic signed [31:0]    pt_x,
  input  logic signed [31:0]    pt_y,
  input  logic signed [31:0]    pt_z,
  output ctpc_pkg::test_res_t   res
);
  import ctpc_pkg::*;

  localparam int W2 = 2 * LIMB_W;
  localparam int W3 = 3 * LIMB_W;

  typedef struct packed {
    logic [8:0]        dsgn;  // signs: ab xyz, ap xyz, bp xyz
    logic [LIMB_W-1:0] ab_x, ab_y, ab_z;
    logic [LIMB_W-1:0] ap_x, ap_y, ap_z;
    logic [LIMB_W-1:0] bp_x, bp_y, bp_z;
    logic [RAD_W-1:0]  ra, rb, rd;
    logic              rd_s;
    logic [W2-1:0]     l, d, ap2;
    logic [W3-1:0]     n;
    logic [OPND_W-1:0] t;
  } opnd_t;

  typedef enum logic {T_IDLE, T_RUN} tstate_t;

  // {sign, magnitude} of p - q
  function automatic logic [LIMB_W:0] sm_sub(logic signed [31:0] p, logic signed [31:0] q);
    logic signed [LIMB_W-1:0] dv;
    dv = LIMB_W'(p) - LIMB_W'(q);
    return dv[LIMB_W-1] ? {1'b1, LIMB_W'(-dv)} : {1'b0, LIMB_W'(dv)};
  endfunction

  // {sign, magnitude} of an operand, zero-extended to four limbs
  function automatic logic [OPND_W:0] fetch(opnd_t s, op_t op);
    logic [OPND_W:0] r;
    case (op)
      OP_ABX:  r = {s.dsgn[0], OPND_W'(s.ab_x)};
      OP_ABY:  r = {s.dsgn[1], OPND_W'(s.ab_y)};
      OP_ABZ:  r = {s.dsgn[2], OPND_W'(s.ab_z)};
      OP_APX:  r = {s.dsgn[3], OPND_W'(s.ap_x)};
      OP_APY:  r = {s.dsgn[4], OPND_W'(s.ap_y)};
      OP_APZ:  r = {s.dsgn[5], OPND_W'(s.ap_z)};
      OP_BPX:  r = {s.dsgn[6], OPND_W'(s.bp_x)};
      OP_BPY:  r = {s.dsgn[7], OPND_W'(s.bp_y)};
      OP_BPZ:  r = {s.dsgn[8], OPND_W'(s.bp_z)};
      OP_RA:   r = {1'b0, OPND_W'(s.ra)};
      OP_RB:   r = {1'b0, OPND_W'(s.rb)};
      OP_RD:   r = {s.rd_s, OPND_W'(s.rd)};
      OP_L:    r = {1'b0, OPND_W'(s.l)};
      OP_D:    r = {1'b0, OPND_W'(s.d)};
      OP_AP2:  r = {1'b0, OPND_W'(s.ap2)};
      OP_N:    r = {1'b0, OPND_W'(s.n)};
      OP_T:    r = {1'b0, s.t};
      default: r = '0;
    endcase
    return r;
  endfunction

  tstate_t state;
  grp_t    grp;
  logic    issuing;
  logic [1:0] ti, li, lj;
  opnd_t   ops;

  logic              s1_v, s1_neg;
  logic [LIMB_W-1:0] s1_x, s1_y;
  logic [2:0]        s1_k;
  logic              s2_v, s2_neg;
  logic [PROD_W-1:0] s2_p;
  logic [2:0]        s2_k;
  logic signed [ACC_W-1:0] acc;

  term_t term;
  logic [1:0] nx, ny;
  logic [OPND_W:0] xv, yv;
  logic settle, acc_le0, launch, finish, hit_val, degen;
  grp_t nxt_grp;
  logic signed [RAD_W:0] rdiff;
  logic [ACC_W-1:0] sh;

  // Current term and its operands
  always_comb begin
    term = term_of(grp, ti);
    nx   = op_limbs(term.x);
    ny   = op_limbs(term.y);
    xv   = fetch(ops, term.x);
    yv   = fetch(ops, term.y);
  end

  assign rdiff   = {1'b0, cap.rad_b} - {1'b0, cap.rad_a};
  assign degen   = (cap.a_x == cap.b_x) && (cap.a_y == cap.b_y) && (cap.a_z == cap.b_z);
  assign settle  = (state == T_RUN) && !issuing && !s1_v && !s2_v;
  assign acc_le0 = acc[ACC_W-1] || (acc == '0);
  assign sh      = ACC_W'(s2_p) << (LIMB_W * s2_k);

  // Branching between groups
  always_comb begin
    nxt_grp = grp;
    launch  = 1'b0;
    finish  = 1'b0;
    hit_val = 1'b0;
    if (state == T_IDLE) begin
      if (start) begin
        launch  = 1'b1;
        nxt_grp = degen ? G_SPA : G_L;
      end
    end else if (settle) begin
      case (grp)
        G_SPA: begin
          finish  = 1'b1;
          hit_val = acc_le0 && (ops.ra != '0);
        end
        G_SPB: begin
          finish  = 1'b1;
          hit_val = acc_le0 && (ops.rb != '0);
        end
        G_L: begin
          launch  = 1'b1;
          nxt_grp = G_D;
        end
        G_D: begin
          launch = 1'b1;
          if (acc_le0)
            nxt_grp = G_SPA;
          else if (acc[W2-1:0] >= ops.l)
            nxt_grp = G_SPB;
          else
            nxt_grp = G_AP2;
        end
        G_AP2: begin
          launch  = 1'b1;
          nxt_grp = G_N;
        end
        G_N: begin
          if (acc_le0) begin
            finish = 1'b1;
          end else begin
            launch  = 1'b1;
            nxt_grp = G_T;
          end
        end
        G_T: begin
          launch  = 1'b1;
          nxt_grp = G_F;
        end
        G_F: begin
          finish  = 1'b1;
          hit_val = acc_le0;
        end
        default: finish = 1'b1;
      endcase
    end
  end

  // Sequencer: state, limb counters and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= T_IDLE;
      grp     <= G_L;
      issuing <= 1'b0;
      ti      <= '0;
      li      <= '0;
      lj      <= '0;
      res     <= '0;
    end else begin
      res.done <= finish;
      if (launch) begin
        state   <= T_RUN;
        grp     <= nxt_grp;
        issuing <= 1'b1;
        ti      <= '0;
        li      <= '0;
        lj      <= '0;
      end else if (issuing) begin
        if (lj == ny) begin
          lj <= '0;
          if (li == nx) begin
            li <= '0;
            if (term.last)
              issuing <= 1'b0;
            else
              ti <= ti + 2'd1;
          end else begin
            li <= li + 2'd1;
          end
        end else begin
          lj <= lj + 2'd1;
        end
      end
      if (finish) begin
        state   <= T_IDLE;
        res.hit <= hit_val;
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= issuing;
      s2_v <= s1_v;
    end
  end

  // Limb fetch, multiply, accumulate
  always_ff @(posedge clk) begin
    s1_x   <= xv[LIMB_W*li +: LIMB_W];
    s1_y   <= yv[LIMB_W*lj +: LIMB_W];
    s1_k   <= {1'b0, li} + {1'b0, lj};
    s1_neg <= xv[OPND_W] ^ yv[OPND_W] ^ term.sub;
    s2_p   <= PROD_W'(s1_x) * PROD_W'(s1_y);
    s2_k   <= s1_k;
    s2_neg <= s1_neg;
    if (launch)
      acc <= '0;
    else if (s2_v)
      acc <= s2_neg ? acc - sh : acc + sh;
  end

  // Operand registers
  always_ff @(posedge clk) begin
    if (state == T_IDLE && start) begin
      {ops.dsgn[0], ops.ab_x} <= sm_sub(cap.b_x, cap.a_x);
      {ops.dsgn[1], ops.ab_y} <= sm_sub(cap.b_y, cap.a_y);
      {ops.dsgn[2], ops.ab_z} <= sm_sub(cap.b_z, cap.a_z);
      {ops.dsgn[3], ops.ap_x} <= sm_sub(pt_x, cap.a_x);
      {ops.dsgn[4], ops.ap_y} <= sm_sub(pt_y, cap.a_y);
      {ops.dsgn[5], ops.ap_z} <= sm_sub(pt_z, cap.a_z);
      {ops.dsgn[6], ops.bp_x} <= sm_sub(pt_x, cap.b_x);
      {ops.dsgn[7], ops.bp_y} <= sm_sub(pt_y, cap.b_y);
      {ops.dsgn[8], ops.bp_z} <= sm_sub(pt_z, cap.b_z);
      ops.ra   <= cap.rad_a;
      ops.rb   <= cap.rad_b;
      ops.rd_s <= rdiff[RAD_W];
      ops.rd   <= rdiff[RAD_W] ? RAD_W'(-rdiff) : RAD_W'(rdiff);
    end
    if (settle) begin
      case (grp)
        G_L:     ops.l   <= acc[W2-1:0];
        G_D:     ops.d   <= acc[W2-1:0];
        G_AP2:   ops.ap2 <= acc[W2-1:0];
        G_N:     ops.n   <= acc[W3-1:0];
        G_T:     ops.t   <= acc[OPND_W-1:0];
        default: ops.t   <= ops.t;
      endcase
    end
  end

endmodule

>>> test/tb_capsule_table_point_containment.sv
`timescale 1ns / 1ps
// Testbench: capsule table point containment, directed table plus random items against a predictor.
module tb_capsule_table_point_containment;
  import ctpc_pkg::*;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 10000000;
  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic signed [23:0] ra, rb;
    logic signed [31:0] px, py, pz;
  } item_t;

  typedef struct {
    logic        hit;
    logic        status;
    logic [10:0] count;
  } answer_t;

  typedef struct {
    item_t   it;
    bit      typed;
    answer_t ans;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = KIND_NOP;
  logic signed [31:0] end_a_x = '0, end_a_y = '0, end_a_z = '0;
  logic signed [31:0] end_b_x = '0, end_b_y = '0, end_b_z = '0;
  logic signed [23:0] radius_a = '0, radius_b = '0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic inside_res, status;
  logic [10:0] stored_count;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  capsule_table_point_containment dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind),
    .end_a_x(end_a_x), .end_a_y(end_a_y), .end_a_z(end_a_z),
    .end_b_x(end_b_x), .end_b_y(end_b_y), .end_b_z(end_b_z),
    .radius_a(radius_a), .radius_b(radius_b),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .inside_res(inside_res), .status(status), .stored_count(stored_count),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Shadow of the capsule table: scaled ends, clamped radii, raw z for aiming queries
  int     zs_now;
  int     n_caps;
  longint cap_ax[DEPTH], cap_ay[DEPTH], cap_az[DEPTH];
  longint cap_bx[DEPTH], cap_by[DEPTH], cap_bz[DEPTH];
  longint cap_ra[DEPTH], cap_rb[DEPTH];
  longint raw_az[DEPTH], raw_bz[DEPTH];

  answer_t pending_results[$];
  row_t    dir_rows[$];
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL capsule_table_point_containment");
      $finish;
    end
  end

  function automatic wide_t w(longint v);
    return wide_t'(v);
  endfunction

  function automatic wide_t dot3(longint x0, longint y0, longint z0,
                                 longint x1, longint y1, longint z1);
    return w(x0) * w(x1) + w(y0) * w(y1) + w(z0) * w(z1);
  endfunction

  // Scaled z: floor(z * scale / 256), saturated to 32 bits
  function automatic longint scaled_z(logic signed [31:0] z);
    longint p, q;
    p = longint'(z) * longint'(zs_now);
    q = p >>> 8;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic bit sphere_holds(longint dx, longint dy, longint dz, longint r);
    if (r <= 0) return 1'b0;
    return dot3(dx, dy, dz, dx, dy, dz) <= w(r) * w(r);
  endfunction

  function automatic bit capsule_holds(int k, longint px, longint py, longint pz);
    longint abx, aby, abz, apx, apy, apz;
    wide_t len2, dp, ap2, num, lhs;
    abx = cap_bx[k] - cap_ax[k];
    aby = cap_by[k] - cap_ay[k];
    abz = cap_bz[k] - cap_az[k];
    apx = px - cap_ax[k];
    apy = py - cap_ay[k];
    apz = pz - cap_az[k];
    // degenerate segment acts as sphere A
    if (abx == 0 && aby == 0 && abz == 0) return sphere_holds(apx, apy, apz, cap_ra[k]);
    len2 = dot3(abx, aby, abz, abx, aby, abz);
    dp = dot3(apx, apy, apz, abx, aby, abz);
    if (dp <= 0) return sphere_holds(apx, apy, apz, cap_ra[k]);
    if (dp >= len2)
      return sphere_holds(px - cap_bx[k], py - cap_by[k], pz - cap_bz[k], cap_rb[k]);
    ap2 = dot3(apx, apy, apz, apx, apy, apz);
    num = w(cap_ra[k]) * len2 + dp * w(cap_rb[k] - cap_ra[k]);
    if (num <= 0) return 1'b0;
    lhs = (ap2 * len2 - dp * dp) * len2;
    return lhs <= num * num;
  endfunction

  // Updates the shadow table and returns the expected result of one item
  function automatic answer_t table_step(item_t it);
    answer_t a;
    longint pz;
    a.hit = 1'b0;
    a.status = 1'b0;
    case (it.kind)
      KIND_INSERT: begin
        if (n_caps >= DEPTH) a.status = 1'b1;
        else begin
          cap_ax[n_caps] = it.ax;
          cap_ay[n_caps] = it.ay;
          cap_az[n_caps] = scaled_z(it.az);
          cap_bx[n_caps] = it.bx;
          cap_by[n_caps] = it.by;
          cap_bz[n_caps] = scaled_z(it.bz);
          cap_ra[n_caps] = (it.ra < 0) ? 0 : it.ra;
          cap_rb[n_caps] = (it.rb < 0) ? 0 : it.rb;
          raw_az[n_caps] = it.az;
          raw_bz[n_caps] = it.bz;
          n_caps++;
        end
      end
      KIND_QUERY: begin
        pz = scaled_z(it.pz);
        for (int k = 0; k < n_caps; k++) begin
          if (capsule_holds(k, it.px, it.py, pz)) begin
            a.hit = 1'b1;
            break;
          end
        end
      end
      KIND_CLEAR: n_caps = 0;
      default: ;
    endcase
    a.count = 11'(n_caps);
    return a;
  endfunction

  // Appends one row to the directed table
  task automatic add_row(row_t r);
    dir_rows = {dir_rows, r};
  endtask

  // Register write while idle; a changed nonzero value empties the table
  task automatic write_zscale(logic [15:0] v);
    wait (pending_results.size() == 0);
    repeat (10) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (v != 0 && int'(v) != zs_now) begin
      zs_now = v;
      n_caps = 0;
    end
  endtask

  // Offers one item, waits for acceptance, records the expectation
  task automatic send_item(item_t it, bit typed, answer_t typed_ans);
    answer_t a;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    kind = it.kind;
    end_a_x = it.ax; end_a_y = it.ay; end_a_z = it.az;
    end_b_x = it.bx; end_b_y = it.by; end_b_z = it.bz;
    radius_a = it.ra; radius_b = it.rb;
    point_x = it.px; point_y = it.py; point_z = it.pz;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    a = table_step(it);
    if (typed) a = typed_ans;
    pending_results = {pending_results, a};
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (inside_res !== e.hit) begin
          $error("inside_res expected %0d actual %0d", e.hit, inside_res);
          errors++;
        end
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
        if (stored_count !== e.count) begin
          $error("stored_count expected %0d actual %0d", e.count, stored_count);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        out_ready = 1'b1;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  function automatic item_t mk_item(logic [1:0] k,
      int ax, int ay, int az, int bx, int by, int bz, int ra, int rb,
      int px, int py, int pz);
    item_t it;
    it.kind = k;
    it.ax = ax; it.ay = ay; it.az = az;
    it.bx = bx; it.by = by; it.bz = bz;
    it.ra = 24'(ra); it.rb = 24'(rb);
    it.px = px; it.py = py; it.pz = pz;
    return it;
  endfunction

  function automatic row_t mk_row(item_t it, bit typed, logic i, logic s, int c);
    row_t r;
    r.it = it;
    r.typed = typed;
    r.ans.hit = i;
    r.ans.status = s;
    r.ans.count = 11'(c);
    return r;
  endfunction

  function automatic int near_val();
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  function automatic item_t wild_item(logic [1:0] k);
    item_t it;
    it.kind = k;
    it.ax = $urandom; it.ay = $urandom; it.az = $urandom;
    it.bx = $urandom; it.by = $urandom; it.bz = $urandom;
    it.ra = 24'($urandom); it.rb = 24'($urandom);
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    return it;
  endfunction

  // Well-formed capsule near the origin, mostly positive radii
  function automatic item_t capsule_item();
    item_t it;
    it = wild_item(KIND_INSERT);
    if ($urandom_range(0, 4) == 0) return it;
    it.ax = near_val(); it.ay = near_val(); it.az = near_val();
    if ($urandom_range(0, 9) == 0) begin
      it.bx = it.ax; it.by = it.ay; it.bz = it.az;
    end else begin
      it.bx = it.ax + near_val(); it.by = it.ay + near_val(); it.bz = it.az + near_val();
    end
    it.ra = 24'(int'($urandom_range(0, 1600)) - 100);
    it.rb = 24'(int'($urandom_range(0, 1600)) - 100);
    return it;
  endfunction

  // Query aimed near a stored capsule, along or around its axis
  function automatic item_t probe_item();
    item_t it;
    int k, t;
    it = wild_item(KIND_QUERY);
    if (n_caps == 0 || $urandom_range(0, 9) < 2) begin
      if ($urandom_range(0, 1) == 0) begin
        it.px = near_val(); it.py = near_val(); it.pz = near_val();
      end
      return it;
    end
    k = $urandom_range(0, n_caps - 1);
    t = $urandom_range(0, 6);
    it.px = 32'(cap_ax[k] + (cap_bx[k] - cap_ax[k]) * (t - 1) / 4
                + int'($urandom_range(0, 1200)) - 600);
    it.py = 32'(cap_ay[k] + (cap_by[k] - cap_ay[k]) * (t - 1) / 4
                + int'($urandom_range(0, 1200)) - 600);
    it.pz = 32'(raw_az[k] + (raw_bz[k] - raw_az[k]) * (t - 1) / 4
                + int'($urandom_range(0, 1200)) - 600);
    return it;
  endfunction

  task automatic random_phase(int n_items);
    int r;
    item_t it;
    answer_t none;
    none = '{1'b0, 1'b0, 11'd0};
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (n_caps > 50) it = wild_item(KIND_CLEAR);
      else if (r < 40) it = capsule_item();
      else if (r < 88) it = probe_item();
      else if (r < 96) it = wild_item(KIND_CLEAR);
      else it = wild_item(KIND_NOP);
      send_item(it, 1'b0, none);
    end
  endtask

  initial begin
    item_t it;
    answer_t none;
    int imax, imin;
    none = '{1'b0, 1'b0, 11'd0};
    imax = 32'sh7FFF_FFFF;
    imin = 32'sh8000_0000;
    zs_now = 256;
    n_caps = 0;

    // Directed rows: empty table, segment regions, degenerate and clamped radii, extremes
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, 0,0,0), 1, 0, 0, 0));
    add_row(mk_row(mk_item(KIND_NOP, 1,2,3, 4,5,6, 7,8, 9,9,9), 1, 0, 0, 0));
    add_row(mk_row(mk_item(KIND_CLEAR, 0,0,0, 0,0,0, 0,0, 0,0,0), 1, 0, 0, 0));
    add_row(mk_row(mk_item(KIND_INSERT, 0,0,0, 2560,0,0, 256,512, 0,0,0),
                   1, 0, 0, 1));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, -200,0,0), 0, 0,0,0));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, -300,0,0), 0, 0,0,0));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, 3060,0,0), 0, 0,0,0));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, 1280,600,0), 0, 0,0,0));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, 1280,300,0), 0, 0,0,0));
    add_row(mk_row(mk_item(KIND_INSERT, 5000,5000,5000, 5000,5000,5000, 100,-5,
                           0,0,0), 0, 0,0,0));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, 5050,5000,5000),
                   0, 0,0,0));
    add_row(mk_row(mk_item(KIND_INSERT, -900,0,0, -900,900,0, 0,0, 0,0,0),
                   0, 0,0,0));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, -900,450,0), 0, 0,0,0));
    add_row(mk_row(mk_item(KIND_INSERT, 0,-900,0, 900,-900,0,
                           -8388608,-8388608, 0,0,0), 0, 0,0,0));
    add_row(mk_row(mk_item(KIND_INSERT, imax,imax,imax, imin,imin,imin,
                           8388607,8388607, 0,0,0), 1, 0, 0, 5));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, imin,imin,imin),
                   0, 0,0,0));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, imax,imax,imax),
                   0, 0,0,0));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, 0,0,imax), 0, 0,0,0));
    add_row(mk_row(mk_item(KIND_CLEAR, 0,0,0, 0,0,0, 0,0, 0,0,0), 1, 0, 0, 0));
    add_row(mk_row(mk_item(KIND_INSERT, 0,0,0, 0,0,4000, 2000,100, 0,0,0),
                   1, 0, 0, 1));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, 900,0,3000), 0, 0,0,0));
    add_row(mk_row(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, 1200,0,1000),
                   0, 0,0,0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].ans);

    // Largest scale: z saturation, then random items under a long output hold-off
    write_zscale(16'hFFFF);
    send_item(mk_item(KIND_INSERT, 0,0,imax, 0,0,imin, 8388607,8388607, 0,0,0), 0, none);
    send_item(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, 0,0,imax), 0, none);
    hold_req = 1'b1;
    random_phase(103);

    // Smallest scale: a batch of capsules, then extreme and aimed queries over it
    write_zscale(16'd1);
    for (int i = 0; i < 40; i++) begin
      it = capsule_item();
      send_item(it, 1'b0, none);
    end
    send_item(mk_item(KIND_QUERY, 0,0,0, 0,0,0, 0,0, imax,imin,imax), 0, none);
    send_item(probe_item(), 1'b0, none);
    send_item(wild_item(KIND_CLEAR), 1'b0, none);
    random_phase(103);

    // Back to unity, then the same value again, which keeps the table
    write_zscale(16'd256);
    random_phase(103);
    write_zscale(16'd256);
    random_phase(103);

    // Random scale, no idling on either side
    write_zscale(16'($urandom_range(2, 65534)));
    calm = 1'b1;
    out_ready = 1'b1;
    random_phase(103);

    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS capsule_table_point_containment");
    end else begin
      $display("FAIL capsule_table_point_containment");
    end
    $finish;
  end

endmodule
